>>> rtl/swq_pkg.sv
// Package for the semaphore wait-queue table.
// Types, operation codes, state codes and fixed widths; no dependencies.
`timescale 1ns / 1ps

package swq_pkg;

   localparam int NPROC         = 16;
   localparam int PROC_W        = 4;
   localparam int KEY_W         = 32;
   localparam int CNT_W         = 5;
   localparam int MAX_PROCS_DEF = 16;

   typedef enum logic [1:0] {
      OP_BLOCK   = 2'd0,
      OP_UNBLOCK = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_PEEK    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PKEY,
      ST_SCAN,
      ST_EXEC,
      ST_U_WR,
      ST_B_WR1,
      ST_B_WR2,
      ST_W_RD,
      ST_W_CHK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PROC_W-1:0] head;
      logic [PROC_W-1:0] tail;
      logic [CNT_W-1:0]  count;
   } desc_entry_type;

   typedef struct packed {
      logic [PROC_W-1:0] link;
      logic [KEY_W-1:0]  key;
   } proc_entry_type;

   typedef struct packed {
      logic              no_free_desc;
      logic              found;
      logic [PROC_W-1:0] result_proc;
   } result_type;

endpackage

>>> rtl/swq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`timescale 1ns / 1ps

interface swq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] sem_addr;
   logic [3:0]  proc_id;
   modport source (output valid, op, sem_addr, proc_id, input ready);
   modport sink   (input valid, op, sem_addr, proc_id, output ready);
endinterface

interface swq_rsp_if;
   logic       valid;
   logic       ready;
   logic       no_free_desc;
   logic       found;
   logic [3:0] result_proc;
   modport source (output valid, no_free_desc, found, result_proc, input ready);
   modport sink   (input valid, no_free_desc, found, result_proc, output ready);
endinterface

>>> rtl/semaphore_wait_queue_table_top.sv
// One item at a time: the next request is taken the cycle after the response loads.
// A lookup scans descriptors one RAM read per cycle until a hit or the end of the table;
// remove then walks the queue, reading each entry and checking it against the process;
// a stalled response holds the sequencer in its final state.
// Reset (synchronous, active high) clears descriptor valid and process queued bits;
// the RAMs need no clearing pass.
// Top level: descriptor RAM, process RAM and the sequencer. Depends on swq_pkg, swq_if, swq_ctrl, swq_ram.
`timescale 1ns / 1ps

module semaphore_wait_queue_table_top #(
   parameter int MAX_PROCS = swq_pkg::MAX_PROCS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   swq_req_if.sink    req_ch,
   swq_rsp_if.source  rsp_ch
);
   import swq_pkg::*;

   localparam int IW = $clog2(MAX_PROCS);

   logic           d_we;
   logic [IW-1:0]  d_waddr, d_raddr;
   desc_entry_type d_wdata, d_rdata;
   logic           p_we;
   logic [PROC_W-1:0] p_waddr, p_raddr;
   proc_entry_type p_wdata, p_rdata;

   swq_ctrl #(.MAX_PROCS(MAX_PROCS)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .d_we    (d_we),
      .d_waddr (d_waddr),
      .d_wdata (d_wdata),
      .d_raddr (d_raddr),
      .d_rdata (d_rdata),
      .p_we    (p_we),
      .p_waddr (p_waddr),
      .p_wdata (p_wdata),
      .p_raddr (p_raddr),
      .p_rdata (p_rdata)
   );

   swq_ram #(.WIDTH($bits(desc_entry_type)), .DEPTH(MAX_PROCS)) u_desc_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   swq_ram #(.WIDTH($bits(proc_entry_type)), .DEPTH(NPROC)) u_proc_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

endmodule

>>> rtl/swq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module swq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/swq_ctrl.sv
// Sequencer for the wait-queue table: descriptor scan, queue walk, updates.
// Depends on swq_pkg and the channel interfaces; drives both RAMs.
`timescale 1ns / 1ps

module swq_ctrl #(
   parameter int MAX_PROCS = swq_pkg::MAX_PROCS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   swq_req_if.sink                           req_ch,
   swq_rsp_if.source                         rsp_ch,
   output logic                              d_we,
   output logic [$clog2(MAX_PROCS)-1:0]      d_waddr,
   output swq_pkg::desc_entry_type           d_wdata,
   output logic [$clog2(MAX_PROCS)-1:0]      d_raddr,
   input  swq_pkg::desc_entry_type           d_rdata,
   output logic                              p_we,
   output logic [swq_pkg::PROC_W-1:0]        p_waddr,
   output swq_pkg::proc_entry_type           p_wdata,
   output logic [swq_pkg::PROC_W-1:0]        p_raddr,
   input  swq_pkg::proc_entry_type           p_rdata
);
   import swq_pkg::*;

   localparam int IW = $clog2(MAX_PROCS);
   localparam int SW = $clog2(MAX_PROCS + 1);
   localparam logic [SW-1:0] SCAN_END = SW'(MAX_PROCS);

   state_type           state_ff, state_in;
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [PROC_W-1:0]   pid_ff;
   logic [SW-1:0]       scan_ff;
   logic                pend_ff;
   logic [IW-1:0]       pidx_ff;
   logic                free_ok_ff;
   logic [IW-1:0]       free_ff;
   logic                hit_ff;
   logic [IW-1:0]       d_ff;
   desc_entry_type      ent_ff;
   logic [PROC_W-1:0]   cur_ff, prev_ff;
   logic [KEY_W-1:0]    prev_key_ff;
   logic                prev_ok_ff;
   logic [CNT_W-1:0]    i_ff;
   result_type          res_ff;
   result_type          out_ff;
   logic                out_valid_ff;
   logic                desc_valid_ff [MAX_PROCS];
   logic                queued_ff [NPROC];

   logic                accept;
   logic                hit, miss_done;
   logic [CNT_W-1:0]    ecnt;
   logic [IW-1:0]       ed;
   logic                out_load;

   assign accept    = req_ch.valid && req_ch.ready;
   assign hit       = pend_ff && desc_valid_ff[pidx_ff] && (d_rdata.key == key_ff);
   assign miss_done = !pend_ff && (scan_ff == SCAN_END);
   assign ecnt      = hit_ff ? ent_ff.count : '0;
   assign ed        = hit_ff ? d_ff : free_ff;
   assign out_load  = (state_ff == ST_FIN) && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(req_ch.op) == OP_REMOVE) begin
                  state_in = queued_ff[req_ch.proc_id] ? ST_PKEY : ST_FIN;
               end else if (op_type'(req_ch.op) == OP_BLOCK && queued_ff[req_ch.proc_id]) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_PKEY:  state_in = ST_SCAN;
         ST_SCAN:  if (hit || miss_done) state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (op_ff)
               OP_UNBLOCK:
                  state_in = (hit_ff && ent_ff.count != '0) ? ST_U_WR : ST_FIN;
               OP_BLOCK:
                  state_in = ((hit_ff || free_ok_ff) && ecnt != '0) ? ST_B_WR1 : ST_FIN;
               OP_REMOVE:
                  state_in = hit_ff ? ST_W_RD : ST_FIN;
               OP_PEEK:
                  state_in = ST_FIN;
               default:
                  state_in = ST_FIN;
            endcase
         end
         ST_U_WR:  state_in = ST_FIN;
         ST_B_WR1: state_in = ST_B_WR2;
         ST_B_WR2: state_in = ST_FIN;
         ST_W_RD:
            state_in = (i_ff < ent_ff.count && !i_ff[CNT_W-1]) ? ST_W_CHK : ST_FIN;
         ST_W_CHK: state_in = (cur_ff == pid_ff) ? ST_FIN : ST_W_RD;
         ST_FIN:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      d_we    = 1'b0;
      d_waddr = ed;
      d_wdata = ent_ff;
      d_raddr = scan_ff[IW-1:0];
      p_we    = 1'b0;
      p_waddr = pid_ff;
      p_wdata = '{link: '0, key: key_ff};
      p_raddr = (state_ff == ST_IDLE) ? req_ch.proc_id : cur_ff;
      unique case (state_ff)
         ST_EXEC: begin
            if (op_ff == OP_UNBLOCK) begin
               p_raddr = ent_ff.head;
            end else if (op_ff == OP_BLOCK && (hit_ff || free_ok_ff)) begin
               if (ecnt == '0) begin
                  d_we    = 1'b1;
                  d_wdata = '{key: key_ff, head: pid_ff, tail: pid_ff, count: CNT_W'(1)};
                  p_we    = 1'b1;
               end else begin
                  p_raddr = ent_ff.tail;
               end
            end
         end
         ST_U_WR: begin
            d_we    = 1'b1;
            d_wdata = '{key: ent_ff.key, head: p_rdata.link, tail: ent_ff.tail,
                        count: ent_ff.count - CNT_W'(1)};
         end
         ST_B_WR1: begin
            d_we    = 1'b1;
            d_wdata = '{key: ent_ff.key, head: ent_ff.head, tail: pid_ff,
                        count: ent_ff.count + CNT_W'(1)};
            p_we    = 1'b1;
            p_waddr = ent_ff.tail;
            p_wdata = '{link: pid_ff, key: p_rdata.key};
         end
         ST_B_WR2: p_we = 1'b1;
         ST_W_CHK: begin
            if (cur_ff == pid_ff) begin
               d_we    = 1'b1;
               d_wdata = '{key: ent_ff.key,
                           head: prev_ok_ff ? ent_ff.head : p_rdata.link,
                           tail: (ent_ff.tail == cur_ff && prev_ok_ff) ? prev_ff : ent_ff.tail,
                           count: ent_ff.count - CNT_W'(1)};
               p_we    = prev_ok_ff;
               p_waddr = prev_ff;
               p_wdata = '{link: p_rdata.link, key: prev_key_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_PROCS; k++) desc_valid_ff[k] <= 1'b0;
         for (int k = 0; k < NPROC; k++) queued_ff[k] <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_EXEC: begin
               if (op_ff == OP_UNBLOCK && hit_ff && ent_ff.count == '0) begin
                  desc_valid_ff[d_ff] <= 1'b0;
               end
               if (op_ff == OP_BLOCK && (hit_ff || free_ok_ff)) begin
                  desc_valid_ff[ed] <= 1'b1;
                  if (ecnt == '0) queued_ff[pid_ff] <= 1'b1;
               end
            end
            ST_U_WR: begin
               queued_ff[ent_ff.head] <= 1'b0;
               if (ent_ff.count == CNT_W'(1)) desc_valid_ff[d_ff] <= 1'b0;
            end
            ST_B_WR2: queued_ff[pid_ff] <= 1'b1;
            ST_W_CHK: if (cur_ff == pid_ff) queued_ff[pid_ff] <= 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            op_ff      <= op_type'(req_ch.op);
            key_ff     <= req_ch.sem_addr;
            pid_ff     <= req_ch.proc_id;
            scan_ff    <= '0;
            pend_ff    <= 1'b0;
            free_ok_ff <= 1'b0;
            res_ff     <= '0;
         end
         ST_PKEY: key_ff <= p_rdata.key;
         ST_SCAN: begin
            pend_ff <= (scan_ff != SCAN_END);
            pidx_ff <= scan_ff[IW-1:0];
            if (scan_ff != SCAN_END) scan_ff <= scan_ff + SW'(1);
            if (pend_ff && !desc_valid_ff[pidx_ff] && !free_ok_ff) begin
               free_ok_ff <= 1'b1;
               free_ff    <= pidx_ff;
            end
            hit_ff <= hit;
            d_ff   <= pidx_ff;
            ent_ff <= d_rdata;
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_PEEK: begin
                  if (hit_ff && ent_ff.count != '0) begin
                     res_ff <= '{no_free_desc: 1'b0, found: 1'b1, result_proc: ent_ff.head};
                  end
               end
               OP_BLOCK: begin
                  if (!hit_ff && !free_ok_ff) begin
                     res_ff <= '{no_free_desc: 1'b1, found: 1'b0, result_proc: '0};
                  end
                  if (!hit_ff) begin
                     ent_ff.key   <= key_ff;
                     ent_ff.count <= '0;
                  end
               end
               OP_REMOVE: begin
                  cur_ff     <= ent_ff.head;
                  prev_ok_ff <= 1'b0;
                  i_ff       <= '0;
               end
               default: ;
            endcase
         end
         ST_U_WR: res_ff <= '{no_free_desc: 1'b0, found: 1'b1, result_proc: ent_ff.head};
         ST_W_CHK: begin
            if (cur_ff == pid_ff) begin
               res_ff <= '{no_free_desc: 1'b0, found: 1'b1, result_proc: pid_ff};
            end else begin
               prev_ff     <= cur_ff;
               prev_key_ff <= p_rdata.key;
               prev_ok_ff  <= 1'b1;
               cur_ff      <= p_rdata.link;
               i_ff        <= i_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
      if (out_load) out_ff <= res_ff;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.no_free_desc = out_ff.no_free_desc;
   assign rsp_ch.found        = out_ff.found;
   assign rsp_ch.result_proc  = out_ff.result_proc;

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("request taken while busy");
   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.found && rsp_ch.no_free_desc))
      else $error("found and no_free_desc both set");
   a_block_nofind: assert property (@(posedge clock) disable iff (reset)
      (out_load && op_ff == OP_BLOCK) |-> !res_ff.found)
      else $error("block reported a process");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(d_we || p_we))
      else $error("memory write while idle");
`endif

endmodule
